/* sv/vdu_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the vector distance unit.
// No dependencies; imported by the top level, controller, datapath and testbench.
package vdu_pkg;

    // Metric selection codes
    localparam logic [2:0] MODE_SQ_EUCLID = 3'd0;
    localparam logic [2:0] MODE_CHEBYSHEV = 3'd1;
    localparam logic [2:0] MODE_COSINE    = 3'd2;
    localparam logic [2:0] MODE_MANHATTAN = 3'd3;

    // Result error codes
    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ERR_ZERO_LENGTH = 2'd2;

    // Fixed point 1.0 in Q2.30
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // Number of quotient bits produced after the integer part
    localparam int DIV_STEPS = 44;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC_LAST,
        S_EVAL,
        S_SQRT,
        S_MUL,
        S_DIV,
        S_DONE
    } vdu_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic sqrt_start;
        logic mul_en;
        logic div_start;
        logic result_load;
    } vdu_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cos_run;
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } vdu_stat_t;

endpackage

/* sv/vector_distance_unit.sv */
`timescale 1ns / 1ps
// Top level of the vector distance unit: controller plus datapath.
// Depends on vdu_pkg, vdu_ctrl and vdu_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_ready  | data_value, cluster_value, last_element
//  output   | out_valid / out_ready| distance, error_code
//  config   | cfg_wr_en            | cfg_wr_data (metric mode)
//
// Element pairs enter one per cycle while in_ready is high; products are registered,
// then summed. A last element passes the accumulators before the result register;
// cosine adds the 32-step root units, a product register and the 44-step divider.
// Reset clears mode, accumulators and the result slot; input waits while a
// vector finishes or its result register is still full.
module vector_distance_unit
    import vdu_pkg::*;
#(
    parameter int VALUE_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [VALUE_BITS-1:0] data_value,
    input  logic signed [VALUE_BITS-1:0] cluster_value,
    input  logic                         last_element,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [47:0]                  distance,
    output logic [1:0]                   error_code,
    input  logic                         cfg_wr_en,
    input  logic [2:0]                   cfg_wr_data
);

    vdu_cmd_t  cmd;
    vdu_stat_t stat;

    vdu_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .last_element (last_element),
        .in_ready     (in_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    vdu_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_value    (data_value),
        .cluster_value (cluster_value),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .distance      (distance),
        .error_code    (error_code),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

/* sv/vdu_isqrt.sv */
`timescale 1ns / 1ps
// Bit-pair iterative integer square root, truncating, one result bit per cycle.
// Depends on nothing outside this file.
module vdu_isqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [61:0] radicand,
    output logic        busy,
    output logic [30:0] root
);

    logic        busy_reg, busy_next;
    logic [61:0] rem_reg, rem_next;
    logic [62:0] res_reg, res_next;
    logic [62:0] bit_reg, bit_next;
    logic [62:0] trial;

    // One restoring step per cycle
    always_comb
    begin
        trial     = res_reg + bit_reg;
        busy_next = busy_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = 63'd1 << 62;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[61:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if ((bit_reg >> 2) == '0)
                busy_next = 1'b0;
        end
    end

    // Hold control flag under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    // Advance working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign root = res_reg[30:0];

endmodule

/* sv/vdu_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the vector distance unit.
// Depends on vdu_pkg for the state, command and status types.
module vdu_ctrl
    import vdu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      last_element,
    output logic      in_ready,
    input  vdu_stat_t stat,
    output vdu_cmd_t  cmd
);

    vdu_state_t state_reg, state_next;
    logic       accept;

    assign accept = in_valid && (state_reg == S_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept && last_element)
                    state_next = S_ACC_LAST;
            S_ACC_LAST:
                state_next = S_EVAL;
            S_EVAL:
                state_next = stat.cos_run ? S_SQRT : S_DONE;
            S_SQRT:
                if (stat.sqrt_done)
                    state_next = S_MUL;
            S_MUL:
                state_next = S_DIV;
            S_DIV:
                if (stat.div_done)
                    state_next = S_DONE;
            S_DONE:
                if (stat.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = accept;
            end
            S_EVAL:
                cmd.sqrt_start = stat.cos_run;
            S_SQRT:
                cmd.mul_en = stat.sqrt_done;
            S_MUL:
                cmd.div_start = 1'b1;
            S_DONE:
            begin
                cmd.result_load = stat.out_free;
                cmd.clear       = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* sv/vdu_datapath.sv */
`timescale 1ns / 1ps
// Datapath: product stage, metric accumulators, cosine finish and result register.
// Depends on vdu_pkg and instantiates vdu_isqrt twice.
module vdu_datapath
    import vdu_pkg::*;
#(
    parameter int VALUE_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [VALUE_BITS-1:0] data_value,
    input  logic signed [VALUE_BITS-1:0] cluster_value,
    input  logic                         cfg_wr_en,
    input  logic [2:0]                   cfg_wr_data,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [47:0]                  distance,
    output logic [1:0]                   error_code,
    input  vdu_cmd_t                     cmd,
    output vdu_stat_t                    stat
);

    localparam int VB   = VALUE_BITS;
    localparam int SQW  = 2 * VB + 2;
    localparam int SUMW = (SQW > 48 ? SQW : 48) + 1;
    localparam int DW   = (2 * VB > 48 ? 2 * VB : 48) + 1;
    localparam logic signed [DW-1:0] DOT_MAX_X = {{(DW - 47){1'b0}}, {47{1'b1}}};
    localparam logic signed [DW-1:0] DOT_MIN_X = {{(DW - 47){1'b1}}, {47{1'b0}}};
    localparam logic [SUMW-1:0]      LIM48     = {{(SUMW - 48){1'b0}}, {48{1'b1}}};

    function automatic logic [47:0] sat_add48(input logic [47:0] acc,
                                              input logic [SQW-1:0] add);
        logic [SUMW-1:0] sum;
        sum = SUMW'(acc) + SUMW'(add);
        return (sum > LIM48) ? 48'hFFFF_FFFF_FFFF : sum[47:0];
    endfunction

    // Product stage
    logic signed [VB:0]     diff;
    logic [VB:0]            dm, dmag, cmag;
    logic [VB:0]            dm_reg;
    logic [SQW-1:0]         sq_reg, dsq_reg, csq_reg;
    logic signed [2*VB-1:0] prod_reg;
    logic                   p1_valid_reg;

    always_comb
    begin
        diff = (VB + 1)'(data_value) - (VB + 1)'(cluster_value);
        dm   = diff[VB] ? (VB + 1)'(-diff) : diff;
        dmag = data_value[VB-1] ? (VB + 1)'(0) - (VB + 1)'(data_value)
                                : (VB + 1)'(data_value);
        cmag = cluster_value[VB-1] ? (VB + 1)'(0) - (VB + 1)'(cluster_value)
                                   : (VB + 1)'(cluster_value);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else
            p1_valid_reg <= cmd.load;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dm_reg   <= dm;
            sq_reg   <= SQW'(dm * dm);
            dsq_reg  <= SQW'(dmag * dmag);
            csq_reg  <= SQW'(cmag * cmag);
            prod_reg <= data_value * cluster_value;
        end
    end

    // Accumulators
    logic [47:0]        sqs_reg, sqs_next;
    logic [47:0]        abs_reg, abs_next;
    logic [16:0]        lgst_reg, lgst_next;
    logic signed [47:0] dot_reg, dot_next;
    logic [47:0]        dlen_reg, dlen_next;
    logic [47:0]        clen_reg, clen_next;
    logic signed [DW-1:0] dot_sum;
    logic [63:0]        dm64;

    always_comb
    begin
        sqs_next  = sqs_reg;
        abs_next  = abs_reg;
        lgst_next = lgst_reg;
        dot_next  = dot_reg;
        dlen_next = dlen_reg;
        clen_next = clen_reg;
        dot_sum   = DW'(dot_reg) + DW'(prod_reg);
        dm64      = 64'(dm_reg);
        if (cmd.clear)
        begin
            sqs_next  = '0;
            abs_next  = '0;
            lgst_next = '0;
            dot_next  = '0;
            dlen_next = '0;
            clen_next = '0;
        end
        else if (p1_valid_reg)
        begin
            sqs_next  = sat_add48(sqs_reg, sq_reg);
            abs_next  = sat_add48(abs_reg, SQW'(dm_reg));
            dlen_next = sat_add48(dlen_reg, dsq_reg);
            clen_next = sat_add48(clen_reg, csq_reg);
            if (dm64 > 64'(lgst_reg))
                lgst_next = (dm64 > 64'h1FFFF) ? 17'h1FFFF : dm64[16:0];
            if (dot_sum > DOT_MAX_X)
                dot_next = DOT_MAX_X[47:0];
            else if (dot_sum < DOT_MIN_X)
                dot_next = DOT_MIN_X[47:0];
            else
                dot_next = dot_sum[47:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqs_reg  <= '0;
            abs_reg  <= '0;
            lgst_reg <= '0;
            dot_reg  <= '0;
            dlen_reg <= '0;
            clen_reg <= '0;
        end
        else
        begin
            sqs_reg  <= sqs_next;
            abs_reg  <= abs_next;
            lgst_reg <= lgst_next;
            dot_reg  <= dot_next;
            dlen_reg <= dlen_next;
            clen_reg <= clen_next;
        end
    end

    // Mode register
    logic [2:0] mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_SQ_EUCLID;
        else if (cfg_wr_en)
            mode_reg <= cfg_wr_data;
    end

    // Cosine: two roots, their product, then the long division
    logic        dbusy, cbusy;
    logic [30:0] droot, croot;
    logic [61:0] p_reg;
    logic [47:0] num;
    logic [61:0] r_reg, r_next;
    logic [43:0] q_reg, q_next;
    logic        qsat_reg, qsat_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [62:0] r2;

    vdu_isqrt u_dsqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand ({dlen_reg, 14'b0}),
        .busy     (dbusy),
        .root     (droot)
    );

    vdu_isqrt u_csqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand ({clen_reg, 14'b0}),
        .busy     (cbusy),
        .root     (croot)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            p_reg <= droot * croot;
    end

    assign num = dot_reg[47] ? 48'(48'd0 - dot_reg) : dot_reg;

    always_comb
    begin
        r_next    = r_reg;
        q_next    = q_reg;
        qsat_next = qsat_reg;
        cnt_next  = cnt_reg;
        r2        = {r_reg, 1'b0};
        if (cmd.div_start)
        begin
            r_next    = 62'(num);
            q_next    = '0;
            qsat_next = (62'(num) >= p_reg);
            cnt_next  = 6'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            if (r2 >= {1'b0, p_reg})
            begin
                r_next = 62'(r2 - {1'b0, p_reg});
                q_next = {q_reg[42:0], 1'b1};
            end
            else
            begin
                r_next = r2[61:0];
                q_next = {q_reg[42:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        q_reg    <= q_next;
        qsat_reg <= qsat_next;
    end

    // Result selection
    logic        len_zero;
    logic [31:0] qc, cos_dist;
    logic [47:0] dist_sel;
    logic [1:0]  err_sel;

    always_comb
    begin
        len_zero = (dlen_reg == '0) || (clen_reg == '0);
        if (qsat_reg || (q_reg > 44'(ONE_Q30)))
            qc = ONE_Q30;
        else
            qc = 32'(q_reg);
        cos_dist = dot_reg[47] ? ONE_Q30 + qc : ONE_Q30 - qc;
        dist_sel = '0;
        err_sel  = ERR_NONE;
        unique case (mode_reg)
            MODE_SQ_EUCLID: dist_sel = sqs_reg;
            MODE_CHEBYSHEV: dist_sel = 48'(lgst_reg);
            MODE_COSINE:
                if (len_zero)
                    err_sel = ERR_ZERO_LENGTH;
                else
                    dist_sel = 48'(cos_dist);
            MODE_MANHATTAN: dist_sel = abs_reg;
            default:        err_sel = ERR_UNSUPPORTED;
        endcase
    end

    // Output register
    logic        ov_reg;
    logic [47:0] dist_reg;
    logic [1:0]  err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.result_load)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            dist_reg <= dist_sel;
            err_reg  <= err_sel;
        end
    end

    assign out_valid      = ov_reg;
    assign distance       = dist_reg;
    assign error_code     = err_reg;
    assign stat.cos_run   = (mode_reg == MODE_COSINE) && !len_zero;
    assign stat.sqrt_done = !dbusy && !cbusy;
    assign stat.div_done  = (cnt_reg == '0);
    assign stat.out_free  = !ov_reg || out_ready;

endmodule

/* sim/vector_distance_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for vector_distance_unit: streams element pairs,
// predicts each distance result and checks it. Depends on vdu_pkg and the RTL.
module vector_distance_unit_tb;
    import vdu_pkg::*;

    typedef struct packed {
        logic signed [15:0] dv;
        logic signed [15:0] cv;
        logic               lst;
        logic [2:0]         mode;
    } pair_t;

    typedef struct packed {
        logic [47:0] dval;
        logic [1:0]  err;
    } dist_t;

    localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;
    localparam longint DOT_HI = 64'sh7FFF_FFFF_FFFF;
    localparam longint DOT_LO = -64'sh7FFF_FFFF_FFFF - 1;
    localparam longint unsigned ONE = 64'h4000_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] data_value = '0;
    logic signed [15:0] cluster_value = '0;
    logic last_element = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [47:0] distance;
    logic [1:0] error_code;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_wr_data = '0;

    pair_t pending_pairs[$];
    dist_t expected_dists[$];
    int fail_count = 0;
    int result_count = 0;
    int accepted_count = 0;
    bit calm = 1'b0;
    bit hold_off = 1'b0;
    bit send_pause = 1'b0;

    // predictor state
    logic [2:0]  mode_model = MODE_SQ_EUCLID;
    longint unsigned sq_acc, abs_acc, max_acc, dlen_acc, clen_acc;
    longint dot_acc;

    vector_distance_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_value(data_value), .cluster_value(cluster_value),
        .last_element(last_element),
        .out_valid(out_valid), .out_ready(out_ready),
        .distance(distance), .error_code(error_code),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #1 clk = ~clk;

    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
        if (b > 64'hFFFF_FFFF_FFFF - a)
            return 64'hFFFF_FFFF_FFFF;
        return a + b;
    endfunction

    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned cosine_distance();
        longint unsigned p, num, q, r;
        p = int_root(dlen_acc << 14) * int_root(clen_acc << 14);
        num = dot_acc < 0 ? -dot_acc : dot_acc;
        if (p == 0)
            return ONE;
        q = num / p;
        r = num % p;
        if (q != 0)
            q = ONE;
        else
        begin
            for (int i = 0; i < 44; i++)
            begin
                r <<= 1;
                q <<= 1;
                if (r >= p)
                begin
                    r -= p;
                    q |= 1;
                end
            end
            if (q > ONE)
                q = ONE;
        end
        return dot_acc >= 0 ? ONE - q : ONE + q;
    endfunction

    // Fold one accepted pair into the accumulators; queue a result on last.
    function automatic void accumulate_pair(pair_t t);
        longint d, c, df, prod;
        longint unsigned dm;
        dist_t e;
        d = t.dv;
        c = t.cv;
        df = d - c;
        dm = df < 0 ? -df : df;
        prod = d * c;
        sq_acc = sat_sum(sq_acc, dm * dm);
        abs_acc = sat_sum(abs_acc, dm);
        if (dm > max_acc)
            max_acc = dm;
        if (prod > 0 && dot_acc > DOT_HI - prod)
            dot_acc = DOT_HI;
        else if (prod < 0 && dot_acc < DOT_LO - prod)
            dot_acc = DOT_LO;
        else
            dot_acc += prod;
        dlen_acc = sat_sum(dlen_acc, longint'(d * d));
        clen_acc = sat_sum(clen_acc, longint'(c * c));
        if (!t.lst)
            return;
        e = '0;
        case (t.mode)
            MODE_SQ_EUCLID: e.dval = sq_acc[47:0];
            MODE_CHEBYSHEV: e.dval = max_acc[47:0];
            MODE_COSINE:
                if (dlen_acc == 0 || clen_acc == 0)
                    e.err = ERR_ZERO_LENGTH;
                else
                    e.dval = 48'(cosine_distance());
            MODE_MANHATTAN: e.dval = abs_acc[47:0];
            default: e.err = ERR_UNSUPPORTED;
        endcase
        expected_dists.push_back(e);
        sq_acc = 0; abs_acc = 0; max_acc = 0; dot_acc = 0; dlen_acc = 0; clen_acc = 0;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want,
                 result_count);
        fail_count++;
    endtask

    // Driver: present queued pairs, predict at acceptance.
    always @(posedge clk)
    begin
        pair_t t;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                t = {data_value, cluster_value, last_element, mode_model};
                accumulate_pair(t);
                accepted_count++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (pending_pairs.size() != 0 && !send_pause
                    && (calm || $urandom_range(99) >= 12))
                begin
                    t = pending_pairs.pop_front();
                    in_valid <= 1'b1;
                    data_value <= t.dv;
                    cluster_value <= t.cv;
                    last_element <= t.lst;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random stalls, compare each transaction with the oldest prediction.
    always @(posedge clk)
    begin
        dist_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_dists.size() == 0)
                    report_mismatch("unexpected result", distance, '0);
                else
                begin
                    e = expected_dists.pop_front();
                    if (distance !== e.dval)
                        report_mismatch("distance", distance, e.dval);
                    if (error_code !== e.err)
                        report_mismatch("error_code", 48'(error_code), 48'(e.err));
                end
                result_count++;
            end
            out_ready <= !hold_off && (calm || $urandom_range(99) >= 12);
        end
    end

    task automatic add_pair(logic signed [15:0] d, logic signed [15:0] c, logic l);
        pending_pairs.push_back({d, c, l, 3'd0});
    endtask

    task automatic drain_and_idle();
        while (pending_pairs.size() != 0 || in_valid || expected_dists.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_mode(logic [2:0] m);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        mode_model = m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random vectors: mostly short, with occasional long ones and extremes.
    task automatic add_random_vectors(int n_pairs);
        int len;
        logic signed [15:0] d, c;
        while (n_pairs > 0)
        begin
            len = ($urandom_range(19) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(5))
                    0: d = 0;
                    1: d = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                    default: d = $urandom;
                endcase
                c = ($urandom_range(7) == 0) ? 16'sh8000 : $urandom;
                add_pair(d, c, i == len - 1);
            end
            n_pairs -= len;
        end
    endtask

    initial
    begin
        logic [2:0] modes[8] = '{MODE_SQ_EUCLID, MODE_CHEBYSHEV, MODE_COSINE,
                                 MODE_MANHATTAN, 3'd4, 3'd7, MODE_COSINE, MODE_SQ_EUCLID};
        sq_acc = 0; abs_acc = 0; max_acc = 0; dot_acc = 0; dlen_acc = 0; clen_acc = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes and zero-length cases, in all four metric modes and unsupported code 4.
        for (int m = 0; m < 5; m++)
        begin
            write_mode(m[2:0]);
            add_pair(16'sh7FFF, 16'sh8000, 1'b0);
            add_pair(16'sh8000, 16'sh7FFF, 1'b1);
            add_pair(16'sh0000, 16'sh1234, 1'b1);
            add_pair(16'sh0100, 16'sh0100, 1'b1);
            add_pair(16'shFF00, 16'sh0100, 1'b1);
            drain_and_idle();
        end

        // Random phases over several modes.
        foreach (modes[k])
        begin
            write_mode(modes[k]);
            calm = (k == 3);
            add_random_vectors(235);
            if (k == 2)
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            if (k == 5)
            begin
                while (pending_pairs.size() > 100)
                    @(posedge clk);
                send_pause = 1'b1;
                while (expected_dists.size() != 0 || in_valid)
                    @(posedge clk);
                send_pause = 1'b0;
            end
            drain_and_idle();
        end
        calm = 1'b0;
        $display("covered %0d pairs and %0d results across all metric modes",
                 accepted_count, result_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout, %0d results still awaited", expected_dists.size());
        $display("*** FAILED ***");
        $finish;
    end
endmodule
